/* design/pnmhdp_pkg.sv */
// ----------------------------------------------------------------------------
// PNM header parser package
// Shared types and constants for the PNM header dimension parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pnmhdp_pkg;

  localparam int unsigned DimW   = 24;
  localparam int unsigned IndexW = 16;
  localparam int unsigned CfgW   = 24;

  localparam logic [DimW-1:0]   MaxDimReset = 24'd1000000;
  localparam logic [IndexW-1:0] WindowReset = 16'd1024;

  localparam logic [7:0] ChP     = 8'h50;  // 'P'
  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChOne   = 8'h31;  // '1'
  localparam logic [7:0] ChSix   = 8'h36;  // '6'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChLf    = 8'h0a;

  typedef enum logic [0:0] {
    CFG_MAX_DIMENSION = 1'b0,
    CFG_WINDOW_BYTES  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_LOADED         = 2'd0,
    ST_NOT_RECOGNIZED = 2'd1,
    ST_GENERIC_ERROR  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_MAGIC0 = 4'd0,
    PH_MAGIC1 = 4'd1,
    PH_MAGIC2 = 4'd2,
    PH_SKIP_W = 4'd3,
    PH_CMT_W  = 4'd4,
    PH_WIDTH  = 4'd5,
    PH_SKIP_H = 4'd6,
    PH_CMT_H  = 4'd7,
    PH_HEIGHT = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [IndexW-1:0] byte_index;
    logic [DimW-1:0]   width_acc;
    logic [DimW-1:0]   height_acc;
    logic              result_given;
  } parse_state_t;

  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
  } parse_result_t;

endpackage

`default_nettype wire

/* design/pnmhdp_in_if.sv */
// ----------------------------------------------------------------------------
// PNM header byte channel
// Valid/ready channel carrying one file byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnmhdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* design/pnmhdp_out_if.sv */
// ----------------------------------------------------------------------------
// PNM header result channel
// Valid/ready channel carrying the parse status and image dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnmhdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] image_width;
  logic [23:0] image_height;

  modport source (output valid, output status, output image_width, output image_height,
                  input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  output ready);
endinterface

`default_nettype wire

/* design/pnmhdp_step.sv */
// ----------------------------------------------------------------------------
// PNM header parse step
// Next-state and result logic for one header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pnmhdp_step (
  input  wire logic [pnmhdp_pkg::DimW-1:0]   max_dimension,
  input  wire logic [pnmhdp_pkg::IndexW-1:0] window_bytes,
  input  wire pnmhdp_pkg::parse_state_t      state_cur,
  input  wire logic [7:0]                    header_byte,
  input  wire logic                          last_byte,
  output pnmhdp_pkg::parse_state_t           state_nxt,
  output pnmhdp_pkg::parse_result_t          result
);
  import pnmhdp_pkg::*;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd11) ||
           (c == 8'd12) || (c == 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Status given when the data runs out in the given phase.
  function automatic status_t end_status(input phase_t p, input logic [DimW-1:0] w,
                                         input logic [DimW-1:0] h);
    status_t s;
    if (p <= PH_MAGIC2) begin
      s = ST_NOT_RECOGNIZED;
    end else if (p == PH_HEIGHT) begin
      s = ((w != '0) && (h != '0)) ? ST_LOADED : ST_GENERIC_ERROR;
    end else begin
      s = ST_GENERIC_ERROR;
    end
    return s;
  endfunction

  logic [3:0]        digit;
  logic [DimW+3:0]   width_x10;
  logic [DimW+3:0]   height_x10;
  logic              width_ok;
  logic              height_ok;
  logic              first_ok;
  phase_t            ph;
  logic [DimW-1:0]   wacc;
  logic [DimW-1:0]   hacc;
  logic [IndexW-1:0] idx;
  logic              dec;
  status_t           dst;

  // For a decimal digit the low nibble is its value.
  assign digit      = header_byte[3:0];
  assign width_x10  = ({4'b0, state_cur.width_acc} << 3) + ({4'b0, state_cur.width_acc} << 1)
                      + {{DimW{1'b0}}, digit};
  assign height_x10 = ({4'b0, state_cur.height_acc} << 3) + ({4'b0, state_cur.height_acc} << 1)
                      + {{DimW{1'b0}}, digit};
  assign width_ok   = width_x10 <= {4'b0, max_dimension};
  assign height_ok  = height_x10 <= {4'b0, max_dimension};
  assign first_ok   = {{(DimW-4){1'b0}}, digit} <= max_dimension;

  always_comb begin
    ph   = state_cur.phase;
    wacc = state_cur.width_acc;
    hacc = state_cur.height_acc;
    idx  = state_cur.byte_index;
    dec  = 1'b0;
    dst  = ST_GENERIC_ERROR;

    if (!state_cur.result_given) begin
      if (state_cur.byte_index >= window_bytes) begin
        dec = 1'b1;
        dst = end_status(ph, wacc, hacc);
      end else begin
        case (state_cur.phase)
          PH_MAGIC0: begin
            if (header_byte == ChP) ph = PH_MAGIC1;
            else begin dec = 1'b1; dst = ST_NOT_RECOGNIZED; end
          end
          PH_MAGIC1: begin
            if ((header_byte >= ChOne) && (header_byte <= ChSix)) ph = PH_MAGIC2;
            else begin dec = 1'b1; dst = ST_NOT_RECOGNIZED; end
          end
          PH_MAGIC2: begin
            if (is_space(header_byte)) ph = PH_SKIP_W;
            else if (header_byte == ChHash) ph = PH_CMT_W;
            else begin dec = 1'b1; dst = ST_NOT_RECOGNIZED; end
          end
          PH_SKIP_W, PH_SKIP_H: begin
            if (is_space(header_byte)) begin
              ph = state_cur.phase;
            end else if (header_byte == ChHash) begin
              ph = (state_cur.phase == PH_SKIP_W) ? PH_CMT_W : PH_CMT_H;
            end else if (is_digit(header_byte)) begin
              if (state_cur.phase == PH_SKIP_W) wacc = {{(DimW-4){1'b0}}, digit};
              else hacc = {{(DimW-4){1'b0}}, digit};
              if (first_ok) ph = (state_cur.phase == PH_SKIP_W) ? PH_WIDTH : PH_HEIGHT;
              else dec = 1'b1;
            end else begin
              dec = 1'b1;
            end
          end
          PH_CMT_W, PH_CMT_H: begin
            if (header_byte == ChLf) begin
              ph = (state_cur.phase == PH_CMT_W) ? PH_SKIP_W : PH_SKIP_H;
            end
          end
          PH_WIDTH: begin
            if (is_digit(header_byte)) begin
              if (width_ok) wacc = width_x10[DimW-1:0];
              else dec = 1'b1;
            end else if (is_space(header_byte)) begin
              ph = PH_SKIP_H;
            end else if (header_byte == ChHash) begin
              ph = PH_CMT_H;
            end else begin
              dec = 1'b1;
            end
          end
          PH_HEIGHT: begin
            if (is_digit(header_byte)) begin
              if (height_ok) hacc = height_x10[DimW-1:0];
              else dec = 1'b1;
            end else begin
              dec = 1'b1;
              dst = end_status(PH_HEIGHT, wacc, hacc);
            end
          end
          default: begin
            dec = 1'b1;
          end
        endcase
        idx = IndexW'(state_cur.byte_index + 1'b1);
        if (!dec && (idx >= window_bytes)) begin
          dec = 1'b1;
          dst = end_status(ph, wacc, hacc);
        end
      end
    end

    if (last_byte && !state_cur.result_given && !dec) begin
      dec = 1'b1;
      dst = end_status(ph, wacc, hacc);
    end

    result.valid        = dec;
    result.status       = dst;
    result.image_width  = (dst == ST_LOADED) ? wacc : '0;
    result.image_height = (dst == ST_LOADED) ? hacc : '0;

    if (last_byte) begin
      state_nxt.phase        = PH_MAGIC0;
      state_nxt.byte_index   = '0;
      state_nxt.width_acc    = '0;
      state_nxt.height_acc   = '0;
      state_nxt.result_given = 1'b0;
    end else begin
      state_nxt.phase        = ph;
      state_nxt.byte_index   = idx;
      state_nxt.width_acc    = wacc;
      state_nxt.height_acc   = hacc;
      state_nxt.result_given = state_cur.result_given | dec;
    end
  end

endmodule

`default_nettype wire

/* design/pnm_header_dimension_parser.sv */
// ----------------------------------------------------------------------------
// PNM header dimension parser
// Checks the PNM magic and extracts the image width and height.
// ----------------------------------------------------------------------------
// The block takes one file byte per item and gives one result per file: a
// status (loaded, format not recognised or generic error) with the width and
// height when loaded. It sustains one byte per clock cycle while the result
// channel does not stall; an accepted byte is held first in an input register
// and then, when the result register is free or emptying, passed via a single
// parse step (one multiply by ten and a compare against the limit) into the
// result register. Bytes after the decision are dropped until the last-byte
// mark, which returns the parser to its start state. There is no clearing
// pass after reset.
`default_nettype none

module pnm_header_dimension_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [pnmhdp_pkg::CfgW-1:0]  cfg_data,
  pnmhdp_in_if.sink                         in_chan,
  pnmhdp_out_if.source                      out_chan
);
  import pnmhdp_pkg::*;

  logic [DimW-1:0]   max_dimension_r;
  logic [IndexW-1:0] window_bytes_r;

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;

  parse_state_t      state_r;
  parse_state_t      state_nxt;
  parse_result_t     step_result;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [DimW-1:0]   out_width_r;
  logic [DimW-1:0]   out_height_r;

  logic              advance;

  // The held byte moves on whenever the result register is free or emptying.
  assign advance      = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dimension_r <= MaxDimReset;
      window_bytes_r  <= WindowReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DIMENSION: max_dimension_r <= cfg_data[DimW-1:0];
        CFG_WINDOW_BYTES:  window_bytes_r  <= cfg_data[IndexW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.header_byte;
      in_last_r <= in_chan.last_byte;
    end
  end

  pnmhdp_step u_step (
    .max_dimension (max_dimension_r),
    .window_bytes  (window_bytes_r),
    .state_cur     (state_r),
    .header_byte   (in_byte_r),
    .last_byte     (in_last_r),
    .state_nxt     (state_nxt),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_MAGIC0;
      state_r.byte_index   <= '0;
      state_r.width_acc    <= '0;
      state_r.height_acc   <= '0;
      state_r.result_given <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_result.valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_result.valid) begin
      out_status_r <= step_result.status;
      out_width_r  <= step_result.image_width;
      out_height_r <= step_result.image_height;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.image_width  = out_width_r;
  assign out_chan.image_height = out_height_r;

`ifndef SYNTHESIS
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_LOADED || out_status_r == ST_NOT_RECOGNIZED ||
                     out_status_r == ST_GENERIC_ERROR))
    else $error("result carries an unused status code");

  a_loaded_dims : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_LOADED) |-> (out_width_r != '0 && out_height_r != '0))
    else $error("loaded result with a zero dimension");

  a_error_dims : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_LOADED) |-> (out_width_r == '0 && out_height_r == '0))
    else $error("failed result with nonzero dimensions");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.result_given) |-> !step_result.valid)
    else $error("second result for the same file");

  a_reset_idle : assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid_r && !in_valid_r))
    else $error("channel valid straight after reset");
`endif

endmodule

`default_nettype wire

/* dv/pnm_header_dimension_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PNM header dimension parser testbench
// Streams directed and random file headers through the parser under several
// register settings and handshake pressures. It predicts each header's result
// byte by byte and compares every result field against that prediction.
// ----------------------------------------------------------------------------

module pnm_header_dimension_parser_tb;
  import pnmhdp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 12;
  localparam int PhaseBytes    = 125;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef struct packed {
    status_t         status;
    logic [DimW-1:0] img_width;
    logic [DimW-1:0] img_height;
  } header_result_t;

  class header_scoreboard;
    logic [DimW-1:0]   max_dim;
    logic [IndexW-1:0] window;
    phase_t            phase;
    logic [IndexW-1:0] index;
    logic [DimW-1:0]   width_acc;
    logic [DimW-1:0]   height_acc;
    bit                decided;
    header_result_t    expected_headers[$];
    int                errors;
    int                status_seen[3];

    function new();
      max_dim = MaxDimReset;
      window  = WindowReset;
      errors  = 0;
      status_seen = '{0, 0, 0};
      restart();
    endfunction

    function void restart();
      phase      = PH_MAGIC0;
      index      = '0;
      width_acc  = '0;
      height_acc = '0;
      decided    = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChLf || c == ChCr || c == ChVt || c == ChFf;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    // Wide enough that the comparison with the limit never wraps.
    function logic [35:0] grow(logic [DimW-1:0] acc, logic [7:0] c);
      return 36'(acc) * 36'd10 + 36'(c - ChZero);
    endfunction

    function void decide(status_t s, logic [DimW-1:0] w, logic [DimW-1:0] h);
      header_result_t r;
      r.status     = s;
      r.img_width  = (s == ST_LOADED) ? w : '0;
      r.img_height = (s == ST_LOADED) ? h : '0;
      expected_headers.push_back(r);
      decided = 1'b1;
    endfunction

    function void decide_dims();
      if (width_acc != 0 && height_acc != 0) begin
        decide(ST_LOADED, width_acc, height_acc);
      end else begin
        decide(ST_GENERIC_ERROR, '0, '0);
      end
    endfunction

    function void end_of_data();
      if (phase <= PH_MAGIC2) begin
        decide(ST_NOT_RECOGNIZED, '0, '0);
      end else if (phase == PH_HEIGHT) begin
        decide_dims();
      end else begin
        decide(ST_GENERIC_ERROR, '0, '0);
      end
    endfunction

    function void parse_byte(logic [7:0] c);
      logic [35:0] grown;
      case (phase)
        PH_MAGIC0: begin
          if (c == ChP) phase = PH_MAGIC1;
          else decide(ST_NOT_RECOGNIZED, '0, '0);
        end
        PH_MAGIC1: begin
          if (c >= ChOne && c <= ChSix) phase = PH_MAGIC2;
          else decide(ST_NOT_RECOGNIZED, '0, '0);
        end
        PH_MAGIC2: begin
          if (is_space(c)) phase = PH_SKIP_W;
          else if (c == ChHash) phase = PH_CMT_W;
          else decide(ST_NOT_RECOGNIZED, '0, '0);
        end
        PH_SKIP_W, PH_SKIP_H: begin
          if (c == ChHash) begin
            phase = (phase == PH_SKIP_W) ? PH_CMT_W : PH_CMT_H;
          end else if (is_digit(c)) begin
            grown = grow('0, c);
            if (grown > 36'(max_dim)) begin
              decide(ST_GENERIC_ERROR, '0, '0);
            end else if (phase == PH_SKIP_W) begin
              width_acc = grown[DimW-1:0];
              phase = PH_WIDTH;
            end else begin
              height_acc = grown[DimW-1:0];
              phase = PH_HEIGHT;
            end
          end else if (!is_space(c)) begin
            decide(ST_GENERIC_ERROR, '0, '0);
          end
        end
        PH_CMT_W, PH_CMT_H: begin
          if (c == ChLf) phase = (phase == PH_CMT_W) ? PH_SKIP_W : PH_SKIP_H;
        end
        PH_WIDTH: begin
          if (is_digit(c)) begin
            grown = grow(width_acc, c);
            if (grown > 36'(max_dim)) decide(ST_GENERIC_ERROR, '0, '0);
            else width_acc = grown[DimW-1:0];
          end else if (is_space(c)) begin
            phase = PH_SKIP_H;
          end else if (c == ChHash) begin
            phase = PH_CMT_H;
          end else begin
            decide(ST_GENERIC_ERROR, '0, '0);
          end
        end
        PH_HEIGHT: begin
          if (is_digit(c)) begin
            grown = grow(height_acc, c);
            if (grown > 36'(max_dim)) decide(ST_GENERIC_ERROR, '0, '0);
            else height_acc = grown[DimW-1:0];
          end else begin
            decide_dims();
          end
        end
        default: decide(ST_GENERIC_ERROR, '0, '0);
      endcase
    endfunction

    // Returns 1 when the byte fell inside the window and was examined.
    function bit note_byte(logic [7:0] data_byte, logic is_last);
      bit examined;
      examined = 1'b0;
      if (!decided) begin
        if (index >= window) begin
          end_of_data();
        end else begin
          parse_byte(data_byte);
          index++;
          examined = 1'b1;
          if (!decided && index >= window) end_of_data();
        end
      end
      if (is_last && !decided) end_of_data();
      if (is_last) restart();
      return examined;
    endfunction

    function void check_header(logic [1:0] status, logic [DimW-1:0] w, logic [DimW-1:0] h);
      header_result_t exp_r;
      if (expected_headers.size() == 0) begin
        $error("unexpected result: status %0d, image_width %0d, image_height %0d",
               status, w, h);
        errors++;
        return;
      end
      exp_r = expected_headers.pop_front();
      if (status < 3) status_seen[status]++;
      if (status != exp_r.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
        errors++;
      end
      if (w != exp_r.img_width) begin
        $error("image_width mismatch: expected %0d, actual %0d", exp_r.img_width, w);
        errors++;
      end
      if (h != exp_r.img_height) begin
        $error("image_height mismatch: expected %0d, actual %0d", exp_r.img_height, h);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [0:0]      cfg_index;
  logic [CfgW-1:0] cfg_data;

  pnmhdp_in_if  in_chan ();
  pnmhdp_out_if out_chan ();

  pnm_header_dimension_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  header_scoreboard sb;
  logic [7:0]       file_bytes[$];
  int               in_idle_pct;
  int               out_stall_pct;
  int               examined_count;
  int               examined_total;
  int               sent_count;
  int               files_total;
  int               idle_cycles;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        sb.check_header(out_chan.status, out_chan.image_width, out_chan.image_height);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.header_byte <= data_byte;
    in_chan.last_byte   <= is_last;
    do @(posedge clk); while (!in_chan.ready);
    if (sb.note_byte(data_byte, is_last)) examined_count++;
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    files_total++;
    file_bytes.delete();
  endtask

  task automatic wait_drained(input int settle);
    in_chan.valid <= 1'b0;
    while (sb.expected_headers.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic configure(input logic [DimW-1:0] max_dim, input logic [IndexW-1:0] window);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_DIMENSION;
    cfg_data  <= max_dim;
    @(negedge clk);
    cfg_index <= CFG_WINDOW_BYTES;
    cfg_data  <= CfgW'(window);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_dim = max_dim;
    sb.window  = window;
    @(negedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] white_byte();
    case ($urandom_range(0, 5))
      0: return ChTab;
      1: return ChLf;
      2: return ChVt;
      3: return ChFf;
      4: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  // Whitespace and comments; a comment may hold any byte, a newline ends it early.
  function automatic void add_separator();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        file_bytes.push_back(ChHash);
        repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
        file_bytes.push_back(ChLf);
      end else begin
        file_bytes.push_back(white_byte());
      end
    end
  endfunction

  // Values cluster around zero and the current limit as well as spreading widely.
  function automatic void add_number();
    longint unsigned v;
    int              n;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = sb.max_dim;
      2: v = longint'(sb.max_dim) + 1;
      3: v = (sb.max_dim > 0) ? sb.max_dim - 1 : 0;
      default: begin
        n = $urandom_range(1, 8);
        v = $urandom_range(0, 10 ** n - 1);
      end
    endcase
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) file_bytes.push_back(ChZero);
    push_text($sformatf("%0d", v));
  endfunction

  function automatic void build_file();
    int k;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      file_bytes.push_back(ChP);
      file_bytes.push_back(ChOne + 8'($urandom_range(0, 5)));
      add_separator();
      add_number();
      add_separator();
      add_number();
      file_bytes.push_back(($urandom_range(0, 1) == 0) ? white_byte()
                                                      : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > k) void'(file_bytes.pop_back());
      end
    end else if (kind < 85) begin
      if ($urandom_range(0, 1) == 0) file_bytes.push_back(ChP);
      repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // A plausible magic followed by a broken body.
      file_bytes.push_back(ChP);
      file_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) add_separator();
      repeat ($urandom_range(1, 5)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    logic [DimW-1:0]   ph_max;
    logic [IndexW-1:0] ph_window;

    sb = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MAX_DIMENSION;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.header_byte = '0;
    in_chan.last_byte   = 1'b0;
    out_chan.ready      = 1'b0;
    in_idle_pct         = 0;
    out_stall_pct       = 0;
    examined_count      = 0;
    examined_total      = 0;
    sent_count          = 0;
    files_total         = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed headers: bad first, second and third magic bytes, data ending
    // before the magic is complete, a comment and a tab around a good header,
    // a missing digit and data ending inside the width.
    file_bytes.push_back(8'hff);
    send_file();
    push_text("P");
    send_file();
    file_bytes.push_back(ChP);
    file_bytes.push_back(8'h00);
    send_file();
    push_text("P7");
    send_file();
    push_text("P5A");
    send_file();
    push_text("P1#\n1\t9\n");
    send_file();
    push_text("P4 x");
    send_file();
    push_text("P6 9");
    send_file();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1:  begin ph_max = 24'd16777215; ph_window = 16'd65535; end
        2:  begin ph_max = 24'd1;        ph_window = 16'd3;     end
        3:  begin ph_max = 24'd999;      ph_window = 16'd1024;  end
        4:  begin ph_max = 24'd65535;    ph_window = 16'd12;    end
        5:  begin ph_max = 24'd123456;   ph_window = 16'd0;     end
        6:  begin ph_max = 24'd16777215; ph_window = 16'd2;     end
        7:  begin ph_max = 24'd9;        ph_window = 16'd1;     end
        8:  begin ph_max = MaxDimReset;  ph_window = WindowReset; end
        9:  begin
          ph_max    = 24'($urandom_range(1, 16777215));
          ph_window = 16'($urandom_range(3, 40));
        end
        10: begin
          ph_max    = 24'($urandom_range(1, 99999));
          ph_window = 16'($urandom_range(3, 65535));
        end
        11: begin ph_max = 24'd0;        ph_window = 16'd30;    end
        default: begin ph_max = MaxDimReset; ph_window = WindowReset; end
      endcase
      if (p != 0) begin
        wait_drained(4);
        configure(ph_max, ph_window);
      end
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 83; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 83; end
        default: begin in_idle_pct = 21; out_stall_pct = 21; end
      endcase
      // Each phase sends whole files until its share of bytes has gone out.
      sent_count = 0;
      while (sent_count < PhaseBytes) begin
        build_file();
        send_file();
      end
    end
    examined_total += examined_count;

    wait_drained(6);
    $display("Ran %0d files (%0d bytes examined) over %0d register settings and four",
             files_total, examined_total, NumPhases);
    $display("handshake pressures: %0d loaded, %0d not recognised, %0d generic errors.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    if (sb.errors == 0 && sb.expected_headers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
